// ===== rtl/core/fatk_pkg.sv =====
// Shared types and constants for the five-axis tool-center-point kinematics block.
// No dependencies; used by fatk_sincos and five_axis_tcp_kinematics.
package fatk_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_TCP_EN     = 3'd0;
    localparam logic [2:0] REG_OFF_EN     = 3'd1;
    localparam logic [2:0] REG_ARM_LEN    = 3'd2;
    localparam logic [2:0] REG_PIVOT_BASE = 3'd3;
    localparam logic [2:0] REG_HOT_X      = 3'd4;
    localparam logic [2:0] REG_HOT_Y      = 3'd5;
    localparam logic [2:0] REG_HOT_Z      = 3'd6;

    localparam logic [31:0] Q30_ONE = 32'h4000_0000;
    localparam logic [24:0] DEG_TO_RAD_Q30 = 25'd18740330;

    // Registers inside the sine/cosine pipeline
    localparam int SC_LAT = 18;
    localparam int SC_STEPS = 6;

    // Exact divide of a 32-bit value by n: (v * MAG) >> (32 + SH), SH = ceil(log2 n)
    localparam logic [32:0] SIN_MAG [SC_STEPS] = '{
        33'((64'd1 << 40) / 156 + 1), 33'((64'd1 << 39) / 110 + 1),
        33'((64'd1 << 39) / 72 + 1),  33'((64'd1 << 38) / 42 + 1),
        33'((64'd1 << 37) / 20 + 1),  33'((64'd1 << 35) / 6 + 1)
    };
    localparam int SIN_SH [SC_STEPS] = '{8, 7, 7, 6, 5, 3};
    localparam logic [32:0] COS_MAG [SC_STEPS] = '{
        33'((64'd1 << 40) / 132 + 1), 33'((64'd1 << 39) / 90 + 1),
        33'((64'd1 << 38) / 56 + 1),  33'((64'd1 << 37) / 30 + 1),
        33'((64'd1 << 36) / 12 + 1),  33'((64'd1 << 33) / 2 + 1)
    };
    localparam int COS_SH [SC_STEPS] = '{8, 7, 6, 5, 4, 1};

    typedef struct packed {
        logic               func;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] yaw;
        logic signed [31:0] tilt;
    } item_t;

endpackage

// ===== rtl/core/fatk_sincos.sv =====
// Pipelined sine and cosine of an angle in signed fixed-point degrees, Q2.30 results.
// Depends on fatk_pkg; takes one angle per cycle.
module fatk_sincos #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic signed [31:0] angle,
    output logic signed [31:0] sin_val,
    output logic signed [31:0] cos_val
);
    import fatk_pkg::*;

    localparam int KSH   = FRAC_BITS + 3;
    localparam int HW    = 32 - KSH;
    localparam int REM_W = FRAC_BITS + 7;
    localparam logic [6:0] NEG_FIX = 7'((45 - ((64'd1 << HW) % 45)) % 45);

    // Stage A: fold the angle, counted in 8-degree units, mod 45 (2^12 = 1 mod 45)
    logic [23:0]    h_ext;
    logic [13:0]    fold_sum;
    logic [12:0]    w_next;
    logic [12:0]    w_reg;
    logic [KSH-1:0] low_reg;

    assign h_ext    = 24'(angle[31:KSH]);
    assign fold_sum = 14'(h_ext[11:0]) + 14'(h_ext[23:12])
                    + (angle[31] ? 14'(NEG_FIX) : 14'd0);
    assign w_next   = 13'(fold_sum[11:0]) + 13'(fold_sum[13:12]);

    always_ff @(posedge clk)
    begin
        w_reg   <= w_next;
        low_reg <= angle[KSH-1:0];
    end

    // Stage B: finish mod 45, split into quadrant and remainder
    logic [23:0]      qe_prod;
    logic [7:0]       qe;
    logic [12:0]      r0;
    logic [5:0]       m45;
    logic [7:0]       r_hi;
    logic [1:0]       q_next;
    logic [7:0]       rh;
    logic [REM_W-1:0] rem_next;
    logic [REM_W-1:0] rem_reg;
    logic [1:0]       q_b_reg;

    assign qe_prod = 24'(w_reg) * 24'd1456;
    assign qe      = qe_prod[23:16];
    assign r0      = w_reg - 13'(13'(qe) * 13'd45);
    assign m45     = (r0 >= 13'd45) ? 6'(r0 - 13'd45) : 6'(r0);
    assign r_hi    = {m45, low_reg[KSH-1:KSH-2]};

    always_comb
    begin
        if (r_hi >= 8'd135)
        begin
            q_next = 2'd3;
            rh     = r_hi - 8'd135;
        end
        else if (r_hi >= 8'd90)
        begin
            q_next = 2'd2;
            rh     = r_hi - 8'd90;
        end
        else if (r_hi >= 8'd45)
        begin
            q_next = 2'd1;
            rh     = r_hi - 8'd45;
        end
        else
        begin
            q_next = 2'd0;
            rh     = r_hi;
        end
    end

    assign rem_next = {rh[5:0], low_reg[KSH-3:0]};

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_b_reg <= q_next;
    end

    // Stage C: degrees to radians, Q2.30
    logic [REM_W+24:0] rad_prod;
    logic [30:0]       x_c_reg;
    logic [1:0]        q_c_reg;

    assign rad_prod = (REM_W+25)'(rem_reg) * (REM_W+25)'(DEG_TO_RAD_Q30);

    always_ff @(posedge clk)
    begin
        x_c_reg <= rad_prod[FRAC_BITS+30:FRAC_BITS];
        q_c_reg <= q_b_reg;
    end

    // Stage D: x squared
    logic [61:0] sq_prod;
    logic [30:0] x_d_reg;
    logic [31:0] x2_d_reg;
    logic [1:0]  q_d_reg;

    assign sq_prod = 62'(x_c_reg) * 62'(x_c_reg);

    always_ff @(posedge clk)
    begin
        x_d_reg  <= x_c_reg;
        x2_d_reg <= sq_prod[61:30];
        q_d_reg  <= q_c_reg;
    end

    // Horner steps: multiply stage then exact constant divide stage
    logic [30:0] xa_reg  [SC_STEPS];
    logic [31:0] x2a_reg [SC_STEPS];
    logic [1:0]  qa_reg  [SC_STEPS];
    logic [31:0] psa_reg [SC_STEPS];
    logic [31:0] pca_reg [SC_STEPS];
    logic [30:0] xb_reg  [SC_STEPS];
    logic [31:0] x2b_reg [SC_STEPS];
    logic [1:0]  qb_reg  [SC_STEPS];
    logic [30:0] tsb_reg [SC_STEPS];
    logic [31:0] tcb_reg [SC_STEPS];

    for (genvar i = 0; i < SC_STEPS; i++)
    begin : g_step
        logic [30:0] x_in;
        logic [31:0] x2_in;
        logic [1:0]  q_in;
        logic [30:0] ts_in;
        logic [30:0] tc_in;
        logic [62:0] ps_prod;
        logic [62:0] pc_prod;
        logic [65:0] ds_prod;
        logic [65:0] dc_prod;
        logic [31:0] ds;
        logic [31:0] dc;

        if (i == 0)
        begin : g_first
            assign x_in  = x_d_reg;
            assign x2_in = x2_d_reg;
            assign q_in  = q_d_reg;
            assign ts_in = Q30_ONE[30:0];
            assign tc_in = Q30_ONE[30:0];
        end
        else
        begin : g_next
            assign x_in  = xb_reg[i-1];
            assign x2_in = x2b_reg[i-1];
            assign q_in  = qb_reg[i-1];
            assign ts_in = tsb_reg[i-1];
            assign tc_in = tcb_reg[i-1][30:0];
        end

        assign ps_prod = 63'(x2_in) * 63'(ts_in);
        assign pc_prod = 63'(x2_in) * 63'(tc_in);

        always_ff @(posedge clk)
        begin
            xa_reg[i]  <= x_in;
            x2a_reg[i] <= x2_in;
            qa_reg[i]  <= q_in;
            psa_reg[i] <= ps_prod[61:30];
            pca_reg[i] <= pc_prod[61:30];
        end

        assign ds_prod = 66'(psa_reg[i]) * 66'(SIN_MAG[i]);
        assign dc_prod = 66'(pca_reg[i]) * 66'(COS_MAG[i]);
        assign ds      = 32'(ds_prod >> (32 + SIN_SH[i]));
        assign dc      = 32'(dc_prod >> (32 + COS_SH[i]));

        always_ff @(posedge clk)
        begin
            xb_reg[i]  <= xa_reg[i];
            x2b_reg[i] <= x2a_reg[i];
            qb_reg[i]  <= qa_reg[i];
            tsb_reg[i] <= 31'(Q30_ONE - ds);
            tcb_reg[i] <= Q30_ONE - dc;
        end
    end

    // Stage F: sine = x * t
    logic [61:0]        s_prod;
    logic signed [31:0] s_f_reg;
    logic signed [31:0] c_f_reg;
    logic [1:0]         q_f_reg;

    assign s_prod = 62'(xb_reg[SC_STEPS-1]) * 62'(tsb_reg[SC_STEPS-1]);

    always_ff @(posedge clk)
    begin
        s_f_reg <= signed'(s_prod[61:30]);
        c_f_reg <= signed'(tcb_reg[SC_STEPS-1]);
        q_f_reg <= qb_reg[SC_STEPS-1];
    end

    // Stage G: quadrant mapping
    logic signed [31:0] sin_next;
    logic signed [31:0] cos_next;
    logic signed [31:0] sin_reg;
    logic signed [31:0] cos_reg;

    always_comb
    begin
        case (q_f_reg)
            2'd0:
            begin
                sin_next = s_f_reg;
                cos_next = c_f_reg;
            end
            2'd1:
            begin
                sin_next = c_f_reg;
                cos_next = -s_f_reg;
            end
            2'd2:
            begin
                sin_next = -s_f_reg;
                cos_next = -c_f_reg;
            end
            default:
            begin
                sin_next = -c_f_reg;
                cos_next = s_f_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        sin_reg <= sin_next;
        cos_reg <= cos_next;
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

// ===== rtl/core/five_axis_tcp_kinematics.sv =====
// Top level of the five-axis tool-center-point kinematics block (C yaw, B tilt head).
// Depends on fatk_pkg and fatk_sincos.
//
// Usage:
//   Items enter on start; an item is taken at each edge where start is high and
//   busy is low. busy stays low, so one item can enter on every clock cycle.
//   Each item carries func (0 tool tip to joint, 1 joint to tool tip), x, y, z
//   and the yaw and tilt angles in signed fixed point.
//   Each result appears on out_x .. out_tilt for one cycle with done high.
//   Results leave in item order.
//   Each item passes an input register, the 18-stage sine/cosine pipeline
//   (angle reduction, radians, x squared, six Horner steps of two stages each,
//   sine product, quadrant mapping), then three stages of products, rounding
//   and saturating sums.
//   The receiver has no hold-off; every result is taken the cycle it shows.
//   Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
//   cfg_ready is always high. Write registers only while no item is in flight.
//   Reset clears the configuration registers to zero, clears the valid bits and done, and drops every item in flight.
module five_axis_tcp_kinematics #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               func,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] yaw_deg,
    input  logic signed [31:0] tilt_deg,
    output logic               done,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic signed [31:0] out_yaw,
    output logic signed [31:0] out_tilt,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import fatk_pkg::*;

    localparam int PIPE_LEN = SC_LAT + 3;
    localparam int LAT      = PIPE_LEN + 1;

    function automatic logic signed [35:0] rnd30(input logic signed [65:0] v);
        logic signed [65:0] t;
        t = v + 66'sd536870912;
        return 36'(t >>> 30);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -40'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = 32'(v);
        return r;
    endfunction

    // Configuration registers
    logic               tcp_en_reg;
    logic               off_en_reg;
    logic signed [31:0] arm_len_reg;
    logic signed [31:0] pivot_base_reg;
    logic signed [31:0] hot_x_reg;
    logic signed [31:0] hot_y_reg;
    logic signed [31:0] hot_z_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tcp_en_reg     <= 1'b0;
            off_en_reg     <= 1'b0;
            arm_len_reg    <= '0;
            pivot_base_reg <= '0;
            hot_x_reg      <= '0;
            hot_y_reg      <= '0;
            hot_z_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_TCP_EN:     tcp_en_reg     <= cfg_data[0];
                REG_OFF_EN:     off_en_reg     <= cfg_data[0];
                REG_ARM_LEN:    arm_len_reg    <= signed'(cfg_data);
                REG_PIVOT_BASE: pivot_base_reg <= signed'(cfg_data);
                REG_HOT_X:      hot_x_reg      <= signed'(cfg_data);
                REG_HOT_Y:      hot_y_reg      <= signed'(cfg_data);
                REG_HOT_Z:      hot_z_reg      <= signed'(cfg_data);
                default:        ;
            endcase
        end
    end

    // Valid bits and item payload travel side by side
    logic  accept;
    logic  valid_reg [PIPE_LEN];
    item_t item_reg  [PIPE_LEN];
    item_t item_next;

    assign accept = start && !busy;
    assign item_next = '{func: func, pos_x: pos_x, pos_y: pos_y, pos_z: pos_z,
                         yaw: yaw_deg, tilt: tilt_deg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PIPE_LEN; k++)
                valid_reg[k] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= accept;
            for (int k = 1; k < PIPE_LEN; k++)
                valid_reg[k] <= valid_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg[0] <= item_next;
        for (int k = 1; k < PIPE_LEN; k++)
            item_reg[k] <= item_reg[k-1];
    end

    // Sine and cosine of both angles
    logic signed [31:0] sc;
    logic signed [31:0] cc;
    logic signed [31:0] sb;
    logic signed [31:0] cb;

    fatk_sincos #(.FRAC_BITS(FRAC_BITS)) u_yaw_sc (
        .clk     (clk),
        .angle   (item_reg[0].yaw),
        .sin_val (sc),
        .cos_val (cc)
    );

    fatk_sincos #(.FRAC_BITS(FRAC_BITS)) u_tilt_sc (
        .clk     (clk),
        .angle   (item_reg[0].tilt),
        .sin_val (sb),
        .cos_val (cb)
    );

    // T1: first products
    logic signed [32:0] piv;
    logic signed [63:0] p_slc;
    logic signed [63:0] p_clc;
    logic signed [63:0] p_csb;
    logic signed [63:0] p_ssb;
    logic signed [64:0] p_zp;
    logic signed [35:0] slc1_reg;
    logic signed [35:0] clc1_reg;
    logic signed [32:0] csb1_reg;
    logic signed [32:0] ssb1_reg;
    logic signed [35:0] zp1_reg;
    logic signed [32:0] piv1_reg;

    assign piv   = 33'(pivot_base_reg) - (off_en_reg ? 33'(hot_z_reg) : 33'sd0);
    assign p_slc = sc * arm_len_reg;
    assign p_clc = cc * arm_len_reg;
    assign p_csb = cc * sb;
    assign p_ssb = sc * sb;
    assign p_zp  = cb * piv;

    always_ff @(posedge clk)
    begin
        slc1_reg <= rnd30(66'(p_slc));
        clc1_reg <= rnd30(66'(p_clc));
        csb1_reg <= 33'(rnd30(66'(p_csb)));
        ssb1_reg <= 33'(rnd30(66'(p_ssb)));
        zp1_reg  <= rnd30(66'(p_zp));
        piv1_reg <= piv;
    end

    // T2: products with pivot length
    logic signed [65:0] p_xp;
    logic signed [65:0] p_yp;
    logic signed [35:0] slc2_reg;
    logic signed [35:0] clc2_reg;
    logic signed [35:0] zp2_reg;
    logic signed [32:0] piv2_reg;
    logic signed [35:0] xp2_reg;
    logic signed [35:0] yp2_reg;

    assign p_xp = csb1_reg * piv1_reg;
    assign p_yp = ssb1_reg * piv1_reg;

    always_ff @(posedge clk)
    begin
        slc2_reg <= slc1_reg;
        clc2_reg <= clc1_reg;
        zp2_reg  <= zp1_reg;
        piv2_reg <= piv1_reg;
        xp2_reg  <= rnd30(p_xp);
        yp2_reg  <= rnd30(p_yp);
    end

    // T3: sums, saturation, pass-through select
    item_t              it3;
    logic signed [39:0] px;
    logic signed [39:0] py;
    logic signed [39:0] pz;
    logic signed [39:0] lc;
    logic signed [39:0] hx;
    logic signed [39:0] hy;
    logic signed [39:0] rx;
    logic signed [39:0] ry;
    logic signed [39:0] rz;
    logic signed [31:0] ox_next;
    logic signed [31:0] oy_next;
    logic signed [31:0] oz_next;

    assign it3 = item_reg[PIPE_LEN-1];
    assign px  = 40'(it3.pos_x);
    assign py  = 40'(it3.pos_y);
    assign pz  = 40'(it3.pos_z);
    assign lc  = 40'(arm_len_reg);
    assign hx  = off_en_reg ? 40'(hot_x_reg) : 40'sd0;
    assign hy  = off_en_reg ? 40'(hot_y_reg) : 40'sd0;

    always_comb
    begin
        if (!it3.func)
        begin
            rx = px - hx - 40'(slc2_reg) + 40'(xp2_reg);
            ry = py - hy + 40'(clc2_reg) - lc + 40'(yp2_reg);
            rz = pz + 40'(zp2_reg) - 40'(piv2_reg);
        end
        else
        begin
            rx = px + 40'(slc2_reg) - 40'(xp2_reg);
            ry = py + lc - 40'(clc2_reg) - 40'(yp2_reg);
            rz = pz + 40'(piv2_reg) - 40'(zp2_reg);
        end
        if (tcp_en_reg)
        begin
            ox_next = sat32(rx);
            oy_next = sat32(ry);
            oz_next = sat32(rz);
        end
        else
        begin
            ox_next = it3.pos_x;
            oy_next = it3.pos_y;
            oz_next = it3.pos_z;
        end
    end

    logic               done_reg;
    logic signed [31:0] out_x_reg;
    logic signed [31:0] out_y_reg;
    logic signed [31:0] out_z_reg;
    logic signed [31:0] out_yaw_reg;
    logic signed [31:0] out_tilt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= valid_reg[PIPE_LEN-1];
    end

    always_ff @(posedge clk)
    begin
        out_x_reg    <= ox_next;
        out_y_reg    <= oy_next;
        out_z_reg    <= oz_next;
        out_yaw_reg  <= it3.yaw;
        out_tilt_reg <= it3.tilt;
    end

    assign done     = done_reg;
    assign out_x    = out_x_reg;
    assign out_y    = out_y_reg;
    assign out_z    = out_z_reg;
    assign out_yaw  = out_yaw_reg;
    assign out_tilt = out_tilt_reg;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LAT done)
        else $error("item did not complete at the fixed latency");

    a_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !tcp_en_reg |-> ##LAT (out_x == $past(pos_x, LAT)
                                         && out_z == $past(pos_z, LAT)))
        else $error("position not passed through with transform off");

    a_angles: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (out_yaw == $past(yaw_deg, LAT) && out_tilt == $past(tilt_deg, LAT)))
        else $error("output angles do not match the accepted item");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without an accepted item");
`endif

endmodule
